// File: sv/scbio_pkg.sv
// Shared types and constants for the sound CPU bus and I/O register block.
// Used by the top level and by its port checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package scbio_pkg;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [1:0]  port_index;
    logic [1:0]  timer_index;
    logic        page_flag;
    logic [7:0]  dsp_return_data;
  } scbio_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] wait_cycles;
    logic [1:0] dsp_request;
    logic [6:0] dsp_register;
    logic [7:0] dsp_write_value;
    logic [4:0] timer_step;
    logic [2:0] timer_enables;
  } scbio_rsp_t;

  localparam logic [2:0] MODE_CPU_READ   = 3'd0;
  localparam logic [2:0] MODE_CPU_WRITE  = 3'd1;
  localparam logic [2:0] MODE_HOST_READ  = 3'd2;
  localparam logic [2:0] MODE_HOST_WRITE = 3'd3;
  localparam logic [2:0] MODE_TIMER_TICK = 3'd4;
  localparam logic [2:0] MODE_ROM_LOAD   = 3'd5;

  localparam logic [1:0] DSP_REQ_NONE  = 2'd0;
  localparam logic [1:0] DSP_REQ_READ  = 2'd1;
  localparam logic [1:0] DSP_REQ_WRITE = 2'd2;

  localparam logic [11:0] IO_PAGE = 12'h00F;

  localparam logic [3:0] IO_TEST    = 4'h0;
  localparam logic [3:0] IO_CONTROL = 4'h1;
  localparam logic [3:0] IO_DSPADDR = 4'h2;
  localparam logic [3:0] IO_DSPDATA = 4'h3;
  localparam logic [3:0] IO_PORT0   = 4'h4;
  localparam logic [3:0] IO_PORT1   = 4'h5;
  localparam logic [3:0] IO_PORT2   = 4'h6;
  localparam logic [3:0] IO_PORT3   = 4'h7;
  localparam logic [3:0] IO_AUX0    = 4'h8;
  localparam logic [3:0] IO_AUX1    = 4'h9;
  localparam logic [3:0] IO_TARGET0 = 4'hA;
  localparam logic [3:0] IO_TARGET1 = 4'hB;
  localparam logic [3:0] IO_TARGET2 = 4'hC;
  localparam logic [3:0] IO_COUNT0  = 4'hD;
  localparam logic [3:0] IO_COUNT1  = 4'hE;
  localparam logic [3:0] IO_COUNT2  = 4'hF;

  localparam logic [7:0] RAM_OFF_BYTE = 8'h5A;
  localparam logic [1:0] NO_TIMER     = 2'd3;

  // Access cost in clocks, indexed by the wait select field.
  localparam logic [3:0][7:0] WAIT_TABLE = {8'd240, 8'd120, 8'd48, 8'd24};

endpackage

`default_nettype wire

// File: sv/sound_cpu_bus_and_io_registers.sv
// Top level: sound CPU memory map with 64 KiB RAM, boot ROM overlay and I/O registers.
// Depends on scbio_pkg for request and result types and register codes.
//
//   channel | valid     | stall      | payload
//   input   | in_valid  | in_stall   | in_req  (scbio_req_t)
//   result  | out_valid | out_stall  | out_rsp (scbio_rsp_t)
//
// For each request, the RAM and ROM are read at the accepting edge,
// and the next cycle applies the request, writes back and loads the output register.
// No new request is accepted while the previous one is still being applied.
// Reset is synchronous and active low; RAM and ROM contents are not cleared.
// A result waiting under out_stall holds off the next request only once it is applied.
`timescale 1ns / 1ps
`default_nettype none

module sound_cpu_bus_and_io_registers #(
  parameter int ROM_BYTES = 64
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  scbio_pkg::scbio_req_t in_req,
  output logic                 out_valid,
  input  wire                  out_stall,
  output scbio_pkg::scbio_rsp_t out_rsp
);
  import scbio_pkg::*;

  localparam int          ROM_AW   = $clog2(ROM_BYTES);
  localparam logic [15:0] ROM_BASE = 16'(65536 - ROM_BYTES);

  logic [7:0] ram_mem [65536];
  logic [7:0] rom_mem [ROM_BYTES];
  logic [7:0] ram_q_r;
  logic [7:0] rom_q_r;

  scbio_req_t req_r;
  logic       exec_valid_r;
  logic       out_valid_r;
  scbio_rsp_t out_rsp_r;
  logic       in_accept;

  logic [3:0][7:0] to_host_r, to_host_nxt;
  logic [3:0][7:0] from_host_r, from_host_nxt;
  logic [1:0][7:0] aux_r, aux_nxt;
  logic [7:0]      dsp_addr_r, dsp_addr_nxt;
  logic [2:0]      tmr_en_r, tmr_en_nxt;
  logic [2:0][7:0] tmr_target_r, tmr_target_nxt;
  logic [2:0][7:0] tmr_pre_r, tmr_pre_nxt;
  logic [2:0][3:0] tmr_out_r, tmr_out_nxt;
  logic            overlay_r, overlay_nxt;
  logic            ram_wr_ok_r, ram_wr_ok_nxt;
  logic            ram_off_r, ram_off_nxt;
  logic            timers_on_r, timers_on_nxt;
  logic            timers_off_r, timers_off_nxt;
  logic [1:0]      ram_wait_r, ram_wait_nxt;
  logic [1:0]      io_wait_r, io_wait_nxt;

  scbio_rsp_t rsp_nxt;
  logic       ram_we;
  logic       rom_we;

  assign in_stall  = exec_valid_r || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ram_q_r <= ram_mem[in_req.address];
    end
    if (ram_we) begin
      ram_mem[req_r.address] <= req_r.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rom_q_r <= rom_mem[in_req.address[ROM_AW-1:0]];
    end
    if (rom_we) begin
      rom_mem[req_r.address[ROM_AW-1:0]] <= req_r.write_data;
    end
  end

  always_comb begin
    logic       io_hit;
    logic       in_ovl;
    logic [7:0] mem_rdata;
    logic [3:0] io_reg;
    logic [1:0] t_idx;
    logic [7:0] pre_inc;

    to_host_nxt    = to_host_r;
    from_host_nxt  = from_host_r;
    aux_nxt        = aux_r;
    dsp_addr_nxt   = dsp_addr_r;
    tmr_en_nxt     = tmr_en_r;
    tmr_target_nxt = tmr_target_r;
    tmr_pre_nxt    = tmr_pre_r;
    tmr_out_nxt    = tmr_out_r;
    overlay_nxt    = overlay_r;
    ram_wr_ok_nxt  = ram_wr_ok_r;
    ram_off_nxt    = ram_off_r;
    timers_on_nxt  = timers_on_r;
    timers_off_nxt = timers_off_r;
    ram_wait_nxt   = ram_wait_r;
    io_wait_nxt    = io_wait_r;
    rsp_nxt        = '0;
    ram_we         = 1'b0;
    rom_we         = 1'b0;

    io_hit    = (req_r.address[15:4] == IO_PAGE);
    in_ovl    = (req_r.address >= ROM_BASE) && overlay_r;
    mem_rdata = in_ovl ? rom_q_r : (ram_off_r ? RAM_OFF_BYTE : ram_q_r);
    io_reg    = req_r.address[3:0];
    t_idx     = req_r.timer_index;
    pre_inc   = 8'h00;

    if (exec_valid_r) begin
      unique case (req_r.mode)
        MODE_CPU_READ: begin
          rsp_nxt.wait_cycles = (io_hit || in_ovl) ? WAIT_TABLE[io_wait_r] :
                                                     WAIT_TABLE[ram_wait_r];
          if (io_hit) begin
            unique case (io_reg) inside
              IO_DSPADDR: rsp_nxt.read_data = dsp_addr_r;
              IO_DSPDATA: begin
                rsp_nxt.dsp_request  = DSP_REQ_READ;
                rsp_nxt.dsp_register = dsp_addr_r[6:0];
                rsp_nxt.read_data    = req_r.dsp_return_data;
              end
              IO_PORT0, IO_PORT1, IO_PORT2, IO_PORT3:
                rsp_nxt.read_data = from_host_r[io_reg[1:0]];
              IO_AUX0, IO_AUX1:
                rsp_nxt.read_data = aux_r[io_reg[0]];
              IO_COUNT0, IO_COUNT1, IO_COUNT2: begin
                rsp_nxt.read_data = {4'h0, tmr_out_r[io_reg[1:0] - 2'd1]};
                tmr_out_nxt[io_reg[1:0] - 2'd1] = 4'h0;
              end
              default: rsp_nxt.read_data = 8'h00;
            endcase
          end else begin
            rsp_nxt.read_data = mem_rdata;
          end
        end
        MODE_CPU_WRITE: begin
          rsp_nxt.wait_cycles = (io_hit || in_ovl) ? WAIT_TABLE[io_wait_r] :
                                                     WAIT_TABLE[ram_wait_r];
          if (io_hit) begin
            unique case (io_reg) inside
              IO_TEST: begin
                if (!req_r.page_flag) begin
                  timers_off_nxt = req_r.write_data[0];
                  ram_wr_ok_nxt  = req_r.write_data[1];
                  ram_off_nxt    = req_r.write_data[2];
                  timers_on_nxt  = req_r.write_data[3];
                  ram_wait_nxt   = req_r.write_data[5:4];
                  io_wait_nxt    = req_r.write_data[7:6];
                end
              end
              IO_CONTROL: begin
                for (int i = 0; i < 3; i++) begin
                  if (!tmr_en_r[i] && req_r.write_data[i]) begin
                    tmr_pre_nxt[i] = 8'h00;
                    tmr_out_nxt[i] = 4'h0;
                  end
                end
                tmr_en_nxt = req_r.write_data[2:0];
                if (req_r.write_data[4]) begin
                  from_host_nxt[0] = 8'h00;
                  from_host_nxt[1] = 8'h00;
                end
                if (req_r.write_data[5]) begin
                  from_host_nxt[2] = 8'h00;
                  from_host_nxt[3] = 8'h00;
                end
                overlay_nxt = req_r.write_data[7];
              end
              IO_DSPADDR: dsp_addr_nxt = req_r.write_data;
              IO_DSPDATA: begin
                if (!dsp_addr_r[7]) begin
                  rsp_nxt.dsp_request     = DSP_REQ_WRITE;
                  rsp_nxt.dsp_register    = dsp_addr_r[6:0];
                  rsp_nxt.dsp_write_value = req_r.write_data;
                end
              end
              IO_PORT0, IO_PORT1, IO_PORT2, IO_PORT3:
                to_host_nxt[io_reg[1:0]] = req_r.write_data;
              IO_AUX0, IO_AUX1:
                aux_nxt[io_reg[0]] = req_r.write_data;
              IO_TARGET0, IO_TARGET1, IO_TARGET2:
                tmr_target_nxt[io_reg[1:0] - 2'd2] = req_r.write_data;
              default: ;
            endcase
          end
          ram_we = ram_wr_ok_nxt && !ram_off_nxt;
        end
        MODE_HOST_READ:  rsp_nxt.read_data = to_host_r[req_r.port_index];
        MODE_HOST_WRITE: from_host_nxt[req_r.port_index] = req_r.write_data;
        MODE_TIMER_TICK: begin
          if (t_idx != NO_TIMER && tmr_en_r[t_idx] && timers_on_r && !timers_off_r) begin
            pre_inc = tmr_pre_r[t_idx] + 8'd1;
            if (pre_inc == tmr_target_r[t_idx]) begin
              tmr_pre_nxt[t_idx] = 8'h00;
              tmr_out_nxt[t_idx] = tmr_out_r[t_idx] + 4'd1;
            end else begin
              tmr_pre_nxt[t_idx] = pre_inc;
            end
          end
        end
        MODE_ROM_LOAD: rom_we = 1'b1;
        default: ;
      endcase
    end

    rsp_nxt.timer_step    = (5'd1 << io_wait_nxt) + (5'd2 << ram_wait_nxt);
    rsp_nxt.timer_enables = tmr_en_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      to_host_r    <= '0;
      from_host_r  <= '0;
      aux_r        <= '0;
      dsp_addr_r   <= '0;
      tmr_en_r     <= '0;
      tmr_target_r <= '0;
      tmr_pre_r    <= '0;
      tmr_out_r    <= '0;
      overlay_r    <= 1'b1;
      ram_wr_ok_r  <= 1'b1;
      ram_off_r    <= 1'b0;
      timers_on_r  <= 1'b1;
      timers_off_r <= 1'b0;
      ram_wait_r   <= '0;
      io_wait_r    <= '0;
    end else begin
      exec_valid_r <= in_accept;
      if (exec_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      to_host_r    <= to_host_nxt;
      from_host_r  <= from_host_nxt;
      aux_r        <= aux_nxt;
      dsp_addr_r   <= dsp_addr_nxt;
      tmr_en_r     <= tmr_en_nxt;
      tmr_target_r <= tmr_target_nxt;
      tmr_pre_r    <= tmr_pre_nxt;
      tmr_out_r    <= tmr_out_nxt;
      overlay_r    <= overlay_nxt;
      ram_wr_ok_r  <= ram_wr_ok_nxt;
      ram_off_r    <= ram_off_nxt;
      timers_on_r  <= timers_on_nxt;
      timers_off_r <= timers_off_nxt;
      ram_wait_r   <= ram_wait_nxt;
      io_wait_r    <= io_wait_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_req;
    end
    if (exec_valid_r) begin
      out_rsp_r <= rsp_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/scbio_checker.sv
// Port checker for the sound CPU bus block, bound to the top level.
// Depends on scbio_pkg for the request and result types.
`timescale 1ns / 1ps
`default_nettype none

module scbio_checker (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_valid,
  input wire                   in_stall,
  input scbio_pkg::scbio_req_t in_req,
  input wire                   out_valid,
  input wire                   out_stall,
  input scbio_pkg::scbio_rsp_t out_rsp
);
  import scbio_pkg::*;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is being applied");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ##1 out_valid)
    else $error("no result two cycles after an accepted request");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_rsp)))
    else $error("stalled result changed or vanished");

  a_wait_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.wait_cycles == 8'd0 || out_rsp.wait_cycles == 8'd24 ||
                   out_rsp.wait_cycles == 8'd48 || out_rsp.wait_cycles == 8'd120 ||
                   out_rsp.wait_cycles == 8'd240))
    else $error("wait cycle count is not a table value");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.timer_step >= 5'd3 && out_rsp.timer_step <= 5'd24 &&
                   out_rsp.dsp_request != 2'd3))
    else $error("timer step or DSP request out of range");

endmodule

bind sound_cpu_bus_and_io_registers scbio_checker u_scbio_checker (.*);

`default_nettype wire
